// ===== rtl/core/cfpa_pkg.sv =====
`default_nettype none

package cfpa_pkg;

    // fractional bits of the q16.16 operands and results
    localparam int FRAC_BITS = 16;

    // quotient bits produced by the divider, one per stage
    localparam int QUOT_BITS = 32;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } cfpa_func_t;

    // front end result: signed numerators as sign and magnitude, divisor
    typedef struct packed {
        cfpa_func_t  func;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic [63:0] den;
    } cfpa_front_t;

    // side data that rides along the divider stages
    typedef struct packed {
        cfpa_func_t  func;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
    } cfpa_meta_t;

    // divider result handed to the output stage
    typedef struct packed {
        cfpa_meta_t             meta;
        logic [QUOT_BITS-1:0]   q_re;
        logic [QUOT_BITS-1:0]   q_im;
    } cfpa_div_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfpa_front.sv =====
`default_nettype none

module cfpa_front
    import cfpa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire cfpa_func_t         in_func,
    input  wire logic signed [31:0] left_real,
    input  wire logic signed [31:0] left_imag,
    input  wire logic signed [31:0] right_real,
    input  wire logic signed [31:0] right_imag,
    output logic                    out_valid,
    output cfpa_front_t             out_data
);

    // stage 1 registers
    logic               v1_reg;
    cfpa_func_t         func1_reg;
    logic signed [32:0] as_re_reg, as_im_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0] d_rr_reg, d_ii_reg;

    // stage 2 registers
    logic               v2_reg;
    cfpa_front_t        f2_reg;

    logic signed [32:0] as_re_next, as_im_next;
    logic signed [64:0] s_re, s_im;
    cfpa_front_t        f2_next;

    // add or subtract at 33 bits
    always_comb begin
        if (in_func == FUNC_SUB) begin
            as_re_next = {left_real[31], left_real} - {right_real[31], right_real};
            as_im_next = {left_imag[31], left_imag} - {right_imag[31], right_imag};
        end else begin
            as_re_next = {left_real[31], left_real} + {right_real[31], right_real};
            as_im_next = {left_imag[31], left_imag} + {right_imag[31], right_imag};
        end
    end

    // stage 1: the six partial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            func1_reg <= in_func;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
            p_rr_reg  <= 64'(left_real) * 64'(right_real);
            p_ii_reg  <= 64'(left_imag) * 64'(right_imag);
            p_ri_reg  <= 64'(left_real) * 64'(right_imag);
            p_ir_reg  <= 64'(left_imag) * 64'(right_real);
            d_rr_reg  <= 64'(right_real) * 64'(right_real);
            d_ii_reg  <= 64'(right_imag) * 64'(right_imag);
        end
    end

    // stage 2: exact sums, then sign and magnitude
    always_comb begin
        case (func1_reg)
            FUNC_MUL: begin
                s_re = {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
                s_im = {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
            end
            FUNC_DIV: begin
                s_re = {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
                s_im = {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
            end
            default: begin
                s_re = {{32{as_re_reg[32]}}, as_re_reg};
                s_im = {{32{as_im_reg[32]}}, as_im_reg};
            end
        endcase
        f2_next.func   = func1_reg;
        f2_next.neg_re = s_re[64];
        f2_next.neg_im = s_im[64];
        f2_next.mag_re = s_re[64] ? 64'(-s_re) : s_re[63:0];
        f2_next.mag_im = s_im[64] ? 64'(-s_im) : s_im[63:0];
        f2_next.den    = d_rr_reg + d_ii_reg;
        f2_next.dz     = (func1_reg == FUNC_DIV) && (d_rr_reg == 64'd0)
                         && (d_ii_reg == 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_reg <= f2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = f2_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cfpa_div.sv =====
`default_nettype none

module cfpa_div
    import cfpa_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire cfpa_front_t in_data,
    output logic             out_valid,
    output cfpa_div_out_t    out_data
);

    // stage index 0 is the setup stage, then one quotient bit per stage
    logic                 vld_reg  [0:QUOT_BITS];
    cfpa_meta_t           meta_reg [0:QUOT_BITS];
    logic [63:0]          den_reg  [0:QUOT_BITS];
    logic [63:0]          rre_reg  [0:QUOT_BITS];
    logic [63:0]          rim_reg  [0:QUOT_BITS];
    logic [31:0]          lre_reg  [0:QUOT_BITS];
    logic [31:0]          lim_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] qre_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] qim_reg  [0:QUOT_BITS];

    logic [95:0]          nre, nim, dsh;
    cfpa_meta_t           meta_next;

    // setup: scale numerators, detect quotients beyond 32 bits
    always_comb begin
        nre = {32'd0, in_data.mag_re} << FRAC_BITS;
        nim = {32'd0, in_data.mag_im} << FRAC_BITS;
        dsh = {in_data.den, 32'd0};
        meta_next.func   = in_data.func;
        meta_next.dz     = in_data.dz;
        meta_next.neg_re = in_data.neg_re;
        meta_next.neg_im = in_data.neg_im;
        meta_next.big_re = nre >= dsh;
        meta_next.big_im = nim >= dsh;
        if (in_data.func == FUNC_MUL) begin
            meta_next.mag_re = in_data.mag_re >> FRAC_BITS;
            meta_next.mag_im = in_data.mag_im >> FRAC_BITS;
        end else begin
            meta_next.mag_re = in_data.mag_re;
            meta_next.mag_im = in_data.mag_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0] <= meta_next;
            den_reg[0]  <= in_data.den;
            rre_reg[0]  <= nre[95:32];
            rim_reg[0]  <= nim[95:32];
            lre_reg[0]  <= nre[31:0];
            lim_reg[0]  <= nim[31:0];
            qre_reg[0]  <= '0;
            qim_reg[0]  <= '0;
        end
    end

    // restoring division, one compare and subtract per stage
    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
        logic [64:0] t_re, t_im, d_ext;
        logic        ge_re, ge_im;
        logic [63:0] rre_next, rim_next;

        always_comb begin
            d_ext    = {1'b0, den_reg[k]};
            t_re     = {rre_reg[k], lre_reg[k][31]};
            t_im     = {rim_reg[k], lim_reg[k][31]};
            ge_re    = t_re >= d_ext;
            ge_im    = t_im >= d_ext;
            rre_next = ge_re ? 64'(t_re - d_ext) : t_re[63:0];
            rim_next = ge_im ? 64'(t_im - d_ext) : t_im[63:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                meta_reg[k+1] <= meta_reg[k];
                den_reg[k+1]  <= den_reg[k];
                rre_reg[k+1]  <= rre_next;
                rim_reg[k+1]  <= rim_next;
                lre_reg[k+1]  <= {lre_reg[k][30:0], 1'b0};
                lim_reg[k+1]  <= {lim_reg[k][30:0], 1'b0};
                qre_reg[k+1]  <= {qre_reg[k][QUOT_BITS-2:0], ge_re};
                qim_reg[k+1]  <= {qim_reg[k][QUOT_BITS-2:0], ge_im};
            end
        end
    end

    assign out_valid     = vld_reg[QUOT_BITS];
    assign out_data.meta = meta_reg[QUOT_BITS];
    assign out_data.q_re = qre_reg[QUOT_BITS];
    assign out_data.q_im = qim_reg[QUOT_BITS];

endmodule

`default_nettype wire

// ===== rtl/core/complex_fixed_point_alu_top.sv =====
// Complex fixed-point unit: two complex q16.16 operands and an operation code
// in, their sum, difference, product or quotient out, saturated to 32 bits per
// part with an overflow flag, and a divide-by-zero flag with a zero result when
// the right operand of a divide is 0+0i. A new item is taken every cycle
// while the result side does not stall; the divider produces one quotient
// bit per pipeline stage. A stall on the result side holds the whole
// pipeline.
`default_nettype none

module complex_fixed_point_alu_top
    import cfpa_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // func[1:0], left_real[33:2], left_imag[65:34], right_real[97:66],
    // right_imag[129:98], zero fill
    input  wire logic [135:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // result_real[31:0], result_imag[63:32], overflow[64],
    // divide_by_zero[65], zero fill
    output logic [71:0]       m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready
);

    logic          en;
    logic          f_valid, d_valid;
    cfpa_front_t   f_data;
    cfpa_div_out_t d_data;

    logic          out_valid_reg;
    logic [31:0]   res_re_reg, res_im_reg;
    logic          ovf_reg, dz_reg;

    logic [63:0]   sm_re, sm_im;
    logic          bg_re, bg_im, ov_re, ov_im;
    logic [31:0]   res_re_next, res_im_next;
    logic          ovf_next;

    // the pipeline moves whenever the output register is free or drained
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    cfpa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_func    (cfpa_func_t'(s_tdata[1:0])),
        .left_real  (s_tdata[33:2]),
        .left_imag  (s_tdata[65:34]),
        .right_real (s_tdata[97:66]),
        .right_imag (s_tdata[129:98]),
        .out_valid  (f_valid),
        .out_data   (f_data)
    );

    cfpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    // pick magnitude source and saturate each part
    always_comb begin
        if (d_data.meta.func == FUNC_DIV) begin
            sm_re = {32'd0, d_data.q_re};
            sm_im = {32'd0, d_data.q_im};
            bg_re = d_data.meta.big_re;
            bg_im = d_data.meta.big_im;
        end else begin
            sm_re = d_data.meta.mag_re;
            sm_im = d_data.meta.mag_im;
            bg_re = 1'b0;
            bg_im = 1'b0;
        end
        ov_re = bg_re || (d_data.meta.neg_re ? (sm_re > 64'h8000_0000)
                                             : (sm_re > 64'h7FFF_FFFF));
        ov_im = bg_im || (d_data.meta.neg_im ? (sm_im > 64'h8000_0000)
                                             : (sm_im > 64'h7FFF_FFFF));
        if (ov_re) begin
            res_re_next = d_data.meta.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res_re_next = d_data.meta.neg_re ? 32'(-sm_re) : sm_re[31:0];
        end
        if (ov_im) begin
            res_im_next = d_data.meta.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res_im_next = d_data.meta.neg_im ? 32'(-sm_im) : sm_im[31:0];
        end
        ovf_next = ov_re || ov_im;
        // zero divisor forces a zero result
        if (d_data.meta.dz) begin
            res_re_next = '0;
            res_im_next = '0;
            ovf_next    = 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            ovf_reg    <= ovf_next;
            dz_reg     <= d_data.meta.dz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, dz_reg, ovf_reg, res_im_reg, res_re_reg};

    // zero divisor always gives a clean zero result
    a_dz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && dz_reg) |-> (res_re_reg == 32'd0 && res_im_reg == 32'd0))
        else $error("divide by zero result not zero");

    // the two flags never come together
    a_flags_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(ovf_reg && dz_reg))
        else $error("overflow and divide by zero both set");

    // overflow means at least one part sits at a limit
    a_ovf_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ovf_reg) |->
            (res_re_reg == 32'h7FFF_FFFF || res_re_reg == 32'h8000_0000 ||
             res_im_reg == 32'h7FFF_FFFF || res_im_reg == 32'h8000_0000))
        else $error("overflow without saturated part");

    // a held result stays put until taken
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== test/tb_complex_fixed_point_alu_top.sv =====
`timescale 1ns / 1ps

module tb_complex_fixed_point_alu_top;
    import cfpa_pkg::*;

    typedef struct {
        cfpa_func_t        func;
        logic signed [31:0] lr, li, rr, ri;
    } op_item_t;

    typedef struct {
        logic [31:0] re, im;
        logic        ovf, dz;
    } alu_result_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic [135:0] s_tdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [71:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready = 0;

    op_item_t    pending_ops[$];
    alu_result_t expected_results[$];
    int          errors = 0;
    int          send_idle_pct = 27;
    int          recv_stall_pct = 58;
    bit          hold_send = 0;

    complex_fixed_point_alu_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // saturate a signed value to 32 bits, flag overflow
    function automatic logic [31:0] clamp32(input logic signed [129:0] v, inout logic ovf);
        if (v > 130'sh7FFFFFFF) begin
            ovf = 1;
            return 32'h7FFFFFFF;
        end
        if (v < -130'sh80000000) begin
            ovf = 1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // quotient truncated toward zero
    function automatic logic signed [129:0] tdiv(input logic signed [129:0] n,
                                                 input logic signed [129:0] d);
        logic [129:0] q;
        q = (n < 0 ? -n : n) / d;
        return n < 0 ? -$signed(q) : $signed(q);
    endfunction

    // expected complex arithmetic result
    function automatic alu_result_t complex_result(input op_item_t it);
        alu_result_t r;
        logic signed [129:0] lr, li, rr, ri, a, b, den;
        lr = it.lr; li = it.li; rr = it.rr; ri = it.ri;
        r.ovf = 0; r.dz = 0; r.re = 0; r.im = 0;
        case (it.func)
            FUNC_ADD: begin a = lr + rr; b = li + ri; end
            FUNC_SUB: begin a = lr - rr; b = li - ri; end
            FUNC_MUL: begin
                a = tdiv(lr * rr - li * ri, 130'sd1 <<< FRAC_BITS);
                b = tdiv(lr * ri + li * rr, 130'sd1 <<< FRAC_BITS);
            end
            default: begin
                den = rr * rr + ri * ri;
                if (den == 0) r.dz = 1;
                else begin
                    a = tdiv((lr * rr + li * ri) <<< FRAC_BITS, den);
                    b = tdiv((li * rr - lr * ri) <<< FRAC_BITS, den);
                end
            end
        endcase
        if (!r.dz) begin
            r.re = clamp32(a, r.ovf);
            r.im = clamp32(b, r.ovf);
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
            4, 5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            6, 7: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input cfpa_func_t f, input logic [31:0] a, b, c, d);
        op_item_t it;
        it.func = f; it.lr = a; it.li = b; it.rr = c; it.ri = d;
        pending_ops.push_back(it);
    endtask

    // item driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(complex_result(pending_ops.pop_front()));
            end
            if ((!s_tvalid || s_tready)) begin
                if (pending_ops.size() > (s_tvalid && s_tready ? 0 : 0) && !hold_send
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1;
                    s_tdata <= {6'b0, pending_ops[0].ri, pending_ops[0].rr,
                                pending_ops[0].li, pending_ops[0].lr, pending_ops[0].func};
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        alu_result_t exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[31:0] !== exp_r.re || m_tdata[63:32] !== exp_r.im
                        || m_tdata[64] !== exp_r.ovf || m_tdata[65] !== exp_r.dz) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp re=%h im=%h ovf=%b dz=%b got re=%h im=%h ovf=%b dz=%b",
                                     exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz, m_tdata[31:0],
                                     m_tdata[63:32], m_tdata[64], m_tdata[65]);
                    end
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    task automatic wait_drain();
        while (pending_ops.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] ext[4];
        ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
        // directed: extremes, every operation, zero divisor
        for (int f = 0; f < 4; f++) begin
            add_op(cfpa_func_t'(f), ext[0], ext[1], ext[0], ext[1]);
            add_op(cfpa_func_t'(f), ext[1], ext[1], ext[1], ext[1]);
            add_op(cfpa_func_t'(f), ext[0], ext[0], ext[3], ext[0]);
            add_op(cfpa_func_t'(f), 32'h00018000, 32'hFFFE0000, 32'h00010000, 32'h00008000);
        end
        add_op(FUNC_DIV, 32'h00010000, 32'h00020000, 0, 0);
        add_op(FUNC_DIV, 0, 0, 0, 0);
        add_op(FUNC_DIV, ext[0], ext[1], 0, 1);
        add_op(FUNC_DIV, 1, 0, ext[1], ext[1]);
        add_op(FUNC_MUL, ext[3], ext[3], ext[3], ext[3]);
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        wait_drain();
        // every result is back; hold the item driver idle
        hold_send = 1;
        repeat (20) @(posedge aclk);
        hold_send = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 27 : phase == 1 ? 58 : 0;
            recv_stall_pct = phase == 0 ? 58 : phase == 1 ? 27 : 0;
            for (int i = 0; i < 134; i++)
                add_op(cfpa_func_t'($urandom_range(0, 3)), rand_part(), rand_part(),
                       rand_part(), rand_part());
            wait_drain();
        end
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cfpa_pkg.sv
rtl/core/cfpa_front.sv
rtl/core/cfpa_div.sv
rtl/core/complex_fixed_point_alu_top.sv
test/tb_complex_fixed_point_alu_top.sv
